/* design/ctpq_pkg.sv */
// shared constants, codes and control structs for the two-class packet queue
// no dependencies
package ctpq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_DATA    = 64;
  localparam int NUM_BUF     = 2 * QUEUE_DEPTH + 1;
  localparam int NUM_ENT     = 2 * QUEUE_DEPTH;
  localparam int BUF_W       = $clog2(NUM_BUF);
  localparam int ENT_W       = $clog2(NUM_ENT);
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int LEN_W       = $clog2(MAX_DATA + 1);
  localparam int ADDR_W      = $clog2(NUM_BUF * MAX_DATA);
  localparam int OLEN_W      = 7;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_CSUM   = 2'd2,
    CMD_DEQ    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_SUM = 3'd1,
    ST_FULL    = 3'd2,
    ST_MALFORM = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_ELEM    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_LD   = 3'b100
  } state_t;

  typedef struct packed {
    logic take;
    logic deq_start;
    logic rd_en;
    logic load_elem;
    logic done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic deq_ok;
    logic out_free;
    logic last_elem;
  } dp_status_t;

endpackage

/* design/ctpq_if.sv */
// valid/ready channel interfaces for packet input and result output
// depends on ctpq_pkg
interface pkt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] arrival_time;
  logic [7:0]  dest_addr;
  logic [7:0]  src_addr;
  logic [7:0]  prio_byte;
  logic [7:0]  payload_length;
  logic [7:0]  byte_value;
  logic        dequeue_select;

  modport source (output valid, command, arrival_time, dest_addr, src_addr, prio_byte,
                  payload_length, byte_value, dequeue_select, input ready);
  modport sink (input valid, command, arrival_time, dest_addr, src_addr, prio_byte,
                payload_length, byte_value, dequeue_select, output ready);
endinterface

interface pkt_out_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic [31:0]                out_time;
  logic [7:0]                 out_dest;
  logic [7:0]                 out_src;
  logic [7:0]                 out_prio;
  logic [ctpq_pkg::OLEN_W-1:0] out_length;
  logic [7:0]                 out_byte;
  logic [7:0]                 out_checksum;
  logic                       last;

  modport source (output valid, status, out_time, out_dest, out_src, out_prio, out_length,
                  out_byte, out_checksum, last, input ready);
  modport sink (input valid, status, out_time, out_dest, out_src, out_prio, out_length,
                out_byte, out_checksum, last, output ready);
endinterface

/* design/ctpq_ctrl.sv */
// controller: input handshake and dequeue streaming sequence
// depends on ctpq_pkg
module ctpq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_command,
  input  ctpq_pkg::dp_status_t dp_stat,
  output logic                 in_ready,
  output ctpq_pkg::ctrl_cmd_t  cmd
);

  ctpq_pkg::state_t state, state_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = (state == ctpq_pkg::S_IDLE) && dp_stat.out_free;
    cmd.take      = in_valid && in_ready;
    cmd.deq_start = cmd.take && (in_command == ctpq_pkg::CMD_DEQ) && dp_stat.deq_ok;
    case (state)
      ctpq_pkg::S_IDLE: begin
        if (cmd.deq_start) state_next = ctpq_pkg::S_RD;
      end
      ctpq_pkg::S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ctpq_pkg::S_LD;
      end
      ctpq_pkg::S_LD: begin
        if (dp_stat.out_free) begin
          cmd.load_elem = 1'b1;
          if (dp_stat.last_elem) begin
            cmd.done   = 1'b1;
            state_next = ctpq_pkg::S_IDLE;
          end else begin
            state_next = ctpq_pkg::S_RD;
          end
        end
      end
      default: state_next = ctpq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ctpq_pkg::S_IDLE;
    else     state <= state_next;
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ctpq_pkg::S_IDLE) |-> !cmd.take)
    else $error("input taken during dequeue stream");
  a_start_to_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.deq_start |=> (state == ctpq_pkg::S_RD))
    else $error("dequeue start did not enter read");
  a_rd_to_ld: assert property (@(posedge clk) disable iff (rst)
    (state == ctpq_pkg::S_RD) |=> (state == ctpq_pkg::S_LD))
    else $error("read not followed by load");

endmodule

/* design/ctpq_dpath.sv */
// datapath: packet assembly, checksum judge, queue bookkeeping, byte buffers, output register
// depends on ctpq_pkg and the channel interfaces
module ctpq_dpath (
  input  logic                clk,
  input  logic                rst,
  pkt_in_if.sink              ingress,
  pkt_out_if.source           egress,
  input  ctpq_pkg::ctrl_cmd_t cmd,
  output ctpq_pkg::dp_status_t dp_stat
);

  // byte buffers, one more than the queues can hold so a free one is always staging
  logic [7:0] buf_mem [ctpq_pkg::NUM_BUF * ctpq_pkg::MAX_DATA];
  logic [7:0] rd_data;

  // queue entries
  logic [31:0]                 e_time [ctpq_pkg::NUM_ENT];
  logic [7:0]                  e_dest [ctpq_pkg::NUM_ENT];
  logic [7:0]                  e_src  [ctpq_pkg::NUM_ENT];
  logic [7:0]                  e_prio [ctpq_pkg::NUM_ENT];
  logic [ctpq_pkg::LEN_W-1:0]  e_len  [ctpq_pkg::NUM_ENT];
  logic [7:0]                  e_csum [ctpq_pkg::NUM_ENT];
  logic [ctpq_pkg::BUF_W-1:0]  e_buf  [ctpq_pkg::NUM_ENT];

  logic [ctpq_pkg::PTR_W-1:0] q_head  [2];
  logic [ctpq_pkg::PTR_W-1:0] q_tail  [2];
  logic [ctpq_pkg::CNT_W-1:0] q_count [2];
  logic [ctpq_pkg::NUM_BUF-1:0] buf_free;

  // open packet
  logic                       pend_open;
  logic [31:0]                pend_time;
  logic [7:0]                 pend_dest, pend_src, pend_prio, pend_len;
  logic [7:0]                 running_xor;
  logic [7:0]                 bytes_received;
  logic [ctpq_pkg::BUF_W-1:0] stage_buf;

  // dequeue stream
  logic                       deq_q;
  logic [ctpq_pkg::ENT_W-1:0] cur_ent;
  logic [ctpq_pkg::LEN_W-1:0] elem_k;

  logic [ctpq_pkg::BUF_W-1:0] first_free;
  logic                       out_valid;
  logic                       tgt_q;
  logic                       len_bad, sum_bad, q_full;
  ctpq_pkg::status_t          judge_st;
  logic                       commit;
  logic                       st_emit;
  ctpq_pkg::status_t          st_code;
  logic                       take_data;
  logic [ctpq_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [ctpq_pkg::LEN_W-1:0] cur_len, elem_cnt;
  logic [ctpq_pkg::ENT_W-1:0] tail_ent;

  always_comb begin
    first_free = '0;
    for (int i = ctpq_pkg::NUM_BUF - 1; i >= 0; i--) begin
      if (buf_free[i]) first_free = ctpq_pkg::BUF_W'(i);
    end
  end

  assign tgt_q    = (pend_prio != 8'd0);
  assign len_bad  = (pend_len > 8'(ctpq_pkg::MAX_DATA)) || (bytes_received != pend_len);
  assign sum_bad  = (running_xor != ingress.byte_value);
  assign q_full   = (q_count[tgt_q] == ctpq_pkg::CNT_W'(ctpq_pkg::QUEUE_DEPTH));
  assign tail_ent = ctpq_pkg::ENT_W'(tgt_q) * ctpq_pkg::ENT_W'(ctpq_pkg::QUEUE_DEPTH)
                    + ctpq_pkg::ENT_W'(q_tail[tgt_q]);

  always_comb begin
    if (len_bad)      judge_st = ctpq_pkg::ST_MALFORM;
    else if (sum_bad) judge_st = ctpq_pkg::ST_BAD_SUM;
    else if (q_full)  judge_st = ctpq_pkg::ST_FULL;
    else              judge_st = ctpq_pkg::ST_OK;
  end

  always_comb begin
    st_emit = 1'b0;
    st_code = ctpq_pkg::ST_MALFORM;
    commit  = 1'b0;
    if (cmd.take) begin
      case (ctpq_pkg::cmd_t'(ingress.command))
        ctpq_pkg::CMD_HEADER: st_emit = pend_open;
        ctpq_pkg::CMD_DATA:   st_emit = 1'b0;
        ctpq_pkg::CMD_CSUM: begin
          st_emit = 1'b1;
          if (pend_open) begin
            st_code = judge_st;
            commit  = (judge_st == ctpq_pkg::ST_OK);
          end
        end
        ctpq_pkg::CMD_DEQ: begin
          st_emit = !dp_stat.deq_ok;
          st_code = ctpq_pkg::ST_EMPTY;
        end
        default: st_emit = 1'b0;
      endcase
    end
  end

  assign take_data = cmd.take && (ingress.command == ctpq_pkg::CMD_DATA) && pend_open;
  assign wr_addr = ctpq_pkg::ADDR_W'(stage_buf) * ctpq_pkg::ADDR_W'(ctpq_pkg::MAX_DATA)
                   + ctpq_pkg::ADDR_W'(bytes_received[ctpq_pkg::IDX_W-1:0]);
  assign rd_addr = ctpq_pkg::ADDR_W'(e_buf[cur_ent]) * ctpq_pkg::ADDR_W'(ctpq_pkg::MAX_DATA)
                   + ctpq_pkg::ADDR_W'(elem_k[ctpq_pkg::IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (take_data && (bytes_received < 8'(ctpq_pkg::MAX_DATA))) buf_mem[wr_addr] <= ingress.byte_value;
    if (cmd.rd_en) rd_data <= buf_mem[rd_addr];
  end

  assign cur_len  = e_len[cur_ent];
  assign elem_cnt = (cur_len == '0) ? ctpq_pkg::LEN_W'(1) : cur_len;

  assign dp_stat.deq_ok    = (q_count[ingress.dequeue_select] != '0);
  assign dp_stat.out_free  = !out_valid || egress.ready;
  assign dp_stat.last_elem = (elem_k + ctpq_pkg::LEN_W'(1) == elem_cnt);

  // entry store
  always_ff @(posedge clk) begin
    if (commit) begin
      e_time[tail_ent] <= pend_time;
      e_dest[tail_ent] <= pend_dest;
      e_src[tail_ent]  <= pend_src;
      e_prio[tail_ent] <= pend_prio;
      e_len[tail_ent]  <= pend_len[ctpq_pkg::LEN_W-1:0];
      e_csum[tail_ent] <= ingress.byte_value;
      e_buf[tail_ent]  <= stage_buf;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      q_head         <= '{default: '0};
      q_tail         <= '{default: '0};
      q_count        <= '{default: '0};
      buf_free       <= '1;
      pend_open      <= 1'b0;
      running_xor    <= '0;
      bytes_received <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.take && ingress.command == ctpq_pkg::CMD_HEADER) begin
        pend_open      <= 1'b1;
        running_xor    <= ingress.dest_addr ^ ingress.src_addr ^ ingress.prio_byte
                          ^ ingress.payload_length;
        bytes_received <= '0;
      end
      if (take_data) begin
        running_xor <= running_xor ^ ingress.byte_value;
        if (bytes_received != 8'hff) bytes_received <= bytes_received + 8'd1;
      end
      if (cmd.take && ingress.command == ctpq_pkg::CMD_CSUM && pend_open) begin
        pend_open      <= 1'b0;
        running_xor    <= '0;
        bytes_received <= '0;
      end
      if (commit) begin
        buf_free[stage_buf] <= 1'b0;
        q_count[tgt_q]      <= q_count[tgt_q] + ctpq_pkg::CNT_W'(1);
        q_tail[tgt_q] <= (q_tail[tgt_q] == ctpq_pkg::PTR_W'(ctpq_pkg::QUEUE_DEPTH - 1))
                         ? '0 : q_tail[tgt_q] + ctpq_pkg::PTR_W'(1);
      end
      if (cmd.done) begin
        buf_free[e_buf[cur_ent]] <= 1'b1;
        q_count[deq_q]           <= q_count[deq_q] - ctpq_pkg::CNT_W'(1);
        q_head[deq_q] <= (q_head[deq_q] == ctpq_pkg::PTR_W'(ctpq_pkg::QUEUE_DEPTH - 1))
                         ? '0 : q_head[deq_q] + ctpq_pkg::PTR_W'(1);
      end
      if (st_emit || cmd.load_elem) out_valid <= 1'b1;
      else if (egress.ready)        out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take && ingress.command == ctpq_pkg::CMD_HEADER) begin
      pend_time <= ingress.arrival_time;
      pend_dest <= ingress.dest_addr;
      pend_src  <= ingress.src_addr;
      pend_prio <= ingress.prio_byte;
      pend_len  <= ingress.payload_length;
      stage_buf <= first_free;
    end
    if (cmd.deq_start) begin
      deq_q   <= ingress.dequeue_select;
      cur_ent <= ctpq_pkg::ENT_W'(ingress.dequeue_select)
                 * ctpq_pkg::ENT_W'(ctpq_pkg::QUEUE_DEPTH)
                 + ctpq_pkg::ENT_W'(q_head[ingress.dequeue_select]);
      elem_k  <= '0;
    end
    if (cmd.load_elem) elem_k <= elem_k + ctpq_pkg::LEN_W'(1);
    if (st_emit) begin
      egress.status       <= st_code;
      egress.out_time     <= '0;
      egress.out_dest     <= '0;
      egress.out_src      <= '0;
      egress.out_prio     <= '0;
      egress.out_length   <= '0;
      egress.out_byte     <= '0;
      egress.out_checksum <= '0;
      egress.last         <= 1'b1;
    end else if (cmd.load_elem) begin
      egress.status       <= ctpq_pkg::ST_ELEM;
      egress.out_time     <= e_time[cur_ent];
      egress.out_dest     <= e_dest[cur_ent];
      egress.out_src      <= e_src[cur_ent];
      egress.out_prio     <= e_prio[cur_ent];
      egress.out_length   <= ctpq_pkg::OLEN_W'(cur_len);
      egress.out_byte     <= (cur_len == '0) ? 8'd0 : rd_data;
      egress.out_checksum <= e_csum[cur_ent];
      egress.last         <= dp_stat.last_elem;
    end
  end

  assign egress.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (q_count[0] <= ctpq_pkg::CNT_W'(ctpq_pkg::QUEUE_DEPTH))
    && (q_count[1] <= ctpq_pkg::CNT_W'(ctpq_pkg::QUEUE_DEPTH)))
    else $error("queue count beyond depth");
  a_free_buf: assert property (@(posedge clk) disable iff (rst)
    buf_free != '0)
    else $error("no free staging buffer");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_elem |-> dp_stat.out_free)
    else $error("element loaded over a pending result");

endmodule

/* design/checked_two_priority_packet_queue.sv */
// two-class packet queue with xor checksum check: one item per cycle for header, data
// and checksum items while idle and the output is free; any status result is registered
// in the cycle after its transaction; a dequeue streams one result per data byte (one for
// an empty packet), each via a registered byte buffer read, then the next item
// synchronous reset empties both queues and closes any open packet; stores need no clearing
// depends on ctpq_pkg, ctpq_if, ctpq_ctrl, ctpq_dpath
module checked_two_priority_packet_queue (
  input logic       clk,
  input logic       rst,
  pkt_in_if.sink    ingress,
  pkt_out_if.source egress
);

  ctpq_pkg::ctrl_cmd_t  cmd;
  ctpq_pkg::dp_status_t dp_stat;
  logic                 rdy;

  ctpq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (ingress.valid),
    .in_command (ingress.command),
    .dp_stat    (dp_stat),
    .in_ready   (rdy),
    .cmd        (cmd)
  );

  ctpq_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .ingress (ingress),
    .egress  (egress),
    .cmd     (cmd),
    .dp_stat (dp_stat)
  );

  assign ingress.ready = rdy;

endmodule
